>>> sv/mhv_pkg.sv
// ---------------------------------------------------------------------------
// mhv_pkg
// Shared types and constants of the map header validator: result status
// codes, configuration register indexes, and the result record.
// ---------------------------------------------------------------------------
`default_nettype none

package mhv_pkg;

    // Header geometry
    localparam int HEADER_BYTES = 28;
    localparam int POS_W        = 5;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HDR_SIZE = 1'b0,
        CFG_MAX_DIM  = 1'b1
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] HDR_SIZE_RST = 16'd28;
    localparam logic [CFG_W-1:0] MAX_DIM_RST  = 16'd4096;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_TRUNCATED      = 3'd1,
        ST_BAD_MAGIC      = 3'd2,
        ST_BAD_HDR_SIZE   = 3'd3,
        ST_ZERO_DIM       = 3'd4,
        ST_DIM_LARGE      = 3'd5,
        ST_TILE_MISMATCH  = 3'd6,
        ST_OVERLAY_EXCESS = 3'd7
    } t_status;

    // Live configuration
    typedef struct packed {
        logic [CFG_W-1:0] hdr_size;
        logic [CFG_W-1:0] max_dim;
    } t_cfg;

    // Result record; the last member sits in the lowest bits
    typedef struct packed {
        logic [31:0]      seed_word;
        logic [31:0]      flag_word;
        logic [31:0]      overlay_count;
        logic [31:0]      terrain_count;
        logic [15:0]      map_height;
        logic [15:0]      map_width;
        logic [15:0]      header_length;
        logic [15:0]      map_version;
        logic [POS_W-1:0] error_offset;
        t_status          status;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

endpackage

`default_nettype wire

>>> sv/mhv_cfg_regs.sv
// ---------------------------------------------------------------------------
// mhv_cfg_regs
// Configuration registers: expected header size and largest dimension.
// ---------------------------------------------------------------------------
`default_nettype none

module mhv_cfg_regs
    import mhv_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    logic [CFG_W-1:0] r_hdr_size;
    logic [CFG_W-1:0] r_max_dim;

    // Write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_size <= HDR_SIZE_RST;
            r_max_dim  <= MAX_DIM_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HDR_SIZE: begin
                    r_hdr_size <= i_cfg_data;
                end
                CFG_MAX_DIM: begin
                    r_max_dim <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.hdr_size = r_hdr_size;
    assign o_cfg.max_dim  = r_max_dim;

endmodule

`default_nettype wire

>>> sv/mhv_parser.sv
// ---------------------------------------------------------------------------
// mhv_parser
// Header byte store, position tracking and the per-byte decision. Each
// accepted item is merged into the store and checked in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module mhv_parser
    import mhv_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire t_cfg       i_cfg,
    output logic            o_result_valid,
    output t_result         o_result
);

    localparam logic [7:0] MAGIC_0 = 8'h4D;
    localparam logic [7:0] MAGIC_1 = 8'h41;
    localparam logic [7:0] MAGIC_2 = 8'h50;
    localparam logic [7:0] MAGIC_3 = 8'h30;

    // Field start offsets
    localparam logic [POS_W-1:0] OFS_MAGIC   = 5'd0;
    localparam logic [POS_W-1:0] OFS_VERSION = 5'd4;
    localparam logic [POS_W-1:0] OFS_HDRLEN  = 5'd6;
    localparam logic [POS_W-1:0] OFS_WIDTH   = 5'd8;
    localparam logic [POS_W-1:0] OFS_HEIGHT  = 5'd10;
    localparam logic [POS_W-1:0] OFS_TERRAIN = 5'd12;
    localparam logic [POS_W-1:0] OFS_OVERLAY = 5'd16;
    localparam logic [POS_W-1:0] OFS_FLAGS   = 5'd20;
    localparam logic [POS_W-1:0] OFS_SEED    = 5'd24;
    localparam logic [POS_W-1:0] HDR_END     = POS_W'(HEADER_BYTES);

    logic [7:0]       r_hdr [HEADER_BYTES];
    logic [POS_W-1:0] r_pos;
    logic             r_sent;
    logic [31:0]      r_area;

    logic [7:0]       n_hdr [HEADER_BYTES];
    logic [POS_W-1:0] n_pos;
    logic             store_en;
    logic             have;
    t_status          status;
    logic [POS_W-1:0] offset;
    logic [15:0]      f_version, f_hdrlen, f_width, f_height;
    logic [31:0]      f_terrain, f_overlay, f_flags, f_seed;
    logic             magic_ok;
    logic [15:0]      s_width, s_height;
    logic [31:0]      area_prod;

    // Start of the field that the position lies in
    function automatic logic [POS_W-1:0] field_start(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] s;
        if      (pos >= OFS_SEED)    s = OFS_SEED;
        else if (pos >= OFS_FLAGS)   s = OFS_FLAGS;
        else if (pos >= OFS_OVERLAY) s = OFS_OVERLAY;
        else if (pos >= OFS_TERRAIN) s = OFS_TERRAIN;
        else if (pos >= OFS_HEIGHT)  s = OFS_HEIGHT;
        else if (pos >= OFS_WIDTH)   s = OFS_WIDTH;
        else if (pos >= OFS_HDRLEN)  s = OFS_HDRLEN;
        else if (pos >= OFS_VERSION) s = OFS_VERSION;
        else                         s = OFS_MAGIC;
        return s;
    endfunction

    assign store_en = i_valid && !r_sent && (r_pos < HDR_END);
    assign n_pos    = r_pos + 5'd1;

    // Merge the incoming byte into a view of the store
    always_comb begin
        for (int i = 0; i < HEADER_BYTES; i++) begin
            n_hdr[i] = (r_pos == POS_W'(i)) ? i_byte : r_hdr[i];
        end
    end

    // Decode fields; a field reads zero until all of its bytes are in
    assign f_version = (n_pos >= OFS_HDRLEN)  ? {n_hdr[5], n_hdr[4]} : 16'd0;
    assign f_hdrlen  = (n_pos >= OFS_WIDTH)   ? {n_hdr[7], n_hdr[6]} : 16'd0;
    assign f_width   = (n_pos >= OFS_HEIGHT)  ? {n_hdr[9], n_hdr[8]} : 16'd0;
    assign f_height  = (n_pos >= OFS_TERRAIN) ? {n_hdr[11], n_hdr[10]} : 16'd0;
    assign f_terrain = (n_pos >= OFS_OVERLAY) ?
                       {n_hdr[15], n_hdr[14], n_hdr[13], n_hdr[12]} : 32'd0;
    assign f_overlay = (n_pos >= OFS_FLAGS) ?
                       {n_hdr[19], n_hdr[18], n_hdr[17], n_hdr[16]} : 32'd0;
    assign f_flags   = (n_pos >= OFS_SEED) ?
                       {n_hdr[23], n_hdr[22], n_hdr[21], n_hdr[20]} : 32'd0;
    assign f_seed    = (n_pos >= HDR_END) ?
                       {n_hdr[27], n_hdr[26], n_hdr[25], n_hdr[24]} : 32'd0;

    assign magic_ok = (n_hdr[0] == MAGIC_0) && (n_hdr[1] == MAGIC_1) &&
                      (n_hdr[2] == MAGIC_2) && (n_hdr[3] == MAGIC_3);

    // Area from stored width and height, taken once the terrain field starts
    assign s_width   = {r_hdr[9], r_hdr[8]};
    assign s_height  = {r_hdr[11], r_hdr[10]};
    assign area_prod = {16'd0, s_width} * {16'd0, s_height};

    // Check points, then truncation on the last byte
    always_comb begin
        have   = 1'b0;
        status = ST_OK;
        offset = OFS_MAGIC;
        if (n_pos == OFS_VERSION) begin
            if (!magic_ok) begin
                have   = 1'b1;
                status = ST_BAD_MAGIC;
                offset = OFS_MAGIC;
            end
        end else if (n_pos == OFS_WIDTH) begin
            if (f_hdrlen != i_cfg.hdr_size) begin
                have   = 1'b1;
                status = ST_BAD_HDR_SIZE;
                offset = OFS_HDRLEN;
            end
        end else if (n_pos == HDR_END) begin
            have = 1'b1;
            if (f_width == 16'd0 || f_height == 16'd0) begin
                status = ST_ZERO_DIM;
                offset = OFS_WIDTH;
            end else if (f_width > i_cfg.max_dim || f_height > i_cfg.max_dim) begin
                status = ST_DIM_LARGE;
                offset = OFS_WIDTH;
            end else if (f_terrain != r_area) begin
                status = ST_TILE_MISMATCH;
                offset = OFS_TERRAIN;
            end else if (f_overlay > f_terrain) begin
                status = ST_OVERLAY_EXCESS;
                offset = OFS_OVERLAY;
            end
        end
        if (!have && i_last) begin
            have   = 1'b1;
            status = ST_TRUNCATED;
            offset = field_start(n_pos);
        end
    end

    assign o_result_valid          = i_valid && !r_sent && have;
    assign o_result.status         = status;
    assign o_result.error_offset   = offset;
    assign o_result.map_version    = f_version;
    assign o_result.header_length  = f_hdrlen;
    assign o_result.map_width      = f_width;
    assign o_result.map_height     = f_height;
    assign o_result.terrain_count  = f_terrain;
    assign o_result.overlay_count  = f_overlay;
    assign o_result.flag_word      = f_flags;
    assign o_result.seed_word      = f_seed;

    // Advance position; rearm on the last byte, hold off after a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sent <= 1'b0;
        end else if (i_valid) begin
            if (i_last) begin
                r_pos  <= '0;
                r_sent <= 1'b0;
            end else if (!r_sent) begin
                r_pos  <= n_pos;
                r_sent <= have;
            end
        end
    end

    // Store header bytes and the area
    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_hdr[r_pos] <= i_byte;
        end
        if (store_en && r_pos == OFS_TERRAIN) begin
            r_area <= area_prod;
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= HDR_END)
        else $error("byte position beyond header");

    a_quiet_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sent |-> !o_result_valid)
        else $error("second result for one buffer");

    a_rearm_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_last) |=> (r_pos == '0 && !r_sent))
        else $error("block not rearmed after last byte");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_last && !r_sent) |-> o_result_valid)
        else $error("buffer ended without a result");

    a_ok_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status == ST_OK) |-> o_result.error_offset == '0)
        else $error("nonzero offset on a good header");

endmodule

`default_nettype wire

>>> sv/mhv_out_reg.sv
// ---------------------------------------------------------------------------
// mhv_out_reg
// Result register on the output stream; holds one item until taken.
// ---------------------------------------------------------------------------
`default_nettype none

module mhv_out_reg
    import mhv_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire t_result             i_result,
    input  wire logic                i_ready,
    output logic                     o_can_load,
    output logic                     o_valid,
    output logic [RESULT_W-1:0]      o_data
);

    logic          r_valid;
    t_result       r_result;

    assign o_can_load = !r_valid || i_ready;

    // Load a new item or drop the one taken downstream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_result;

endmodule

`default_nettype wire

>>> sv/map_header_validator_top.sv
// ---------------------------------------------------------------------------
// map_header_validator_top
// Streaming checker for a 28-byte little-endian map header.
// ---------------------------------------------------------------------------
// The block takes one header byte per clock and returns at most one result
// per buffer, in the cycle after the byte that decides it (the magic after byte
// 4, the header size after byte 8, the full checks after byte 28, or
// truncation on an early last mark). Each byte is merged and checked in the
// cycle it is accepted, and the result lands in a single output register;
// s_axis_tready drops only while that register is full and not being taken,
// so the sustained rate is one byte per cycle. Bytes after a result are
// swallowed until the last mark. Width times height is computed once as the
// terrain field begins, so the final checks need only compares.
// ---------------------------------------------------------------------------
`default_nettype none

module map_header_validator_top
    import mhv_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input stream; tdata: byte_value[7:0]
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [7:0]           i_s_axis_tdata,
    input  wire logic                 i_s_axis_tlast,
    // Result stream; tdata from bit 0: status[2:0], error_offset[7:3],
    // map_version[23:8], header_length[39:24], map_width[55:40],
    // map_height[71:56], terrain_count[103:72], overlay_count[135:104],
    // flag_word[167:136], seed_word[199:168]
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [RESULT_W-1:0]       o_m_axis_tdata,
    // Configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg    cfg;
    t_result result;
    logic    result_valid;
    logic    can_load;
    logic    in_accept;

    assign o_s_axis_tready = can_load;
    assign in_accept       = i_s_axis_tvalid && can_load;

    mhv_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    mhv_parser u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_accept),
        .i_byte         (i_s_axis_tdata),
        .i_last         (i_s_axis_tlast),
        .i_cfg          (cfg),
        .o_result_valid (result_valid),
        .o_result       (result)
    );

    mhv_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (result_valid),
        .i_result   (result),
        .i_ready    (i_m_axis_tready),
        .o_can_load (can_load),
        .o_valid    (o_m_axis_tvalid),
        .o_data     (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> bench/map_header_checker.sv
// ---------------------------------------------------------------------------
// map_header_checker
// Watches the byte stream, the register writes and the result stream of the
// map header validator, predicts one verdict per buffer and compares every
// accepted result with the oldest pending verdict, field by field.
// ---------------------------------------------------------------------------

module map_header_checker
    import mhv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Byte stream as seen at the block's input
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_in_last,
    // Result stream as seen at the block's output
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [RESULT_W-1:0]  i_out_data,
    // Register writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Status toward the bench top
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // Start offsets of the header fields
    localparam logic [POS_W-1:0] OFS_MAGIC    = 5'd0;
    localparam logic [POS_W-1:0] OFS_VERSION  = 5'd4;
    localparam logic [POS_W-1:0] OFS_HDR_SIZE = 5'd6;
    localparam logic [POS_W-1:0] OFS_WIDTH    = 5'd8;
    localparam logic [POS_W-1:0] OFS_HEIGHT   = 5'd10;
    localparam logic [POS_W-1:0] OFS_TERRAIN  = 5'd12;
    localparam logic [POS_W-1:0] OFS_OVERLAY  = 5'd16;
    localparam logic [POS_W-1:0] OFS_FLAGS    = 5'd20;
    localparam logic [POS_W-1:0] OFS_SEED     = 5'd24;

    // Live copy of the registers
    logic [CFG_W-1:0] hdr_size_reg;
    logic [CFG_W-1:0] max_dim_reg;

    // Header bytes collected for the current buffer
    logic [7:0]       hdr_mem [HEADER_BYTES];
    int               stored;
    logic             answered;

    t_result          verdict_q [$];
    int               fails   = 0;
    int               checked = 0;

    // Little-endian field of n bytes at ofs; zero until all of it has arrived
    function automatic logic [31:0] hdr_field(input int ofs, input int n);
        logic [31:0] v;
        v = '0;
        if (stored >= ofs + n)
            for (int k = n - 1; k >= 0; k--)
                v = {v[23:0], hdr_mem[ofs + k]};
        return v;
    endfunction

    // Start of the field that a buffer ending after pos bytes was reading
    function automatic logic [POS_W-1:0] field_start_of(input int pos);
        if (pos >= OFS_SEED)     return OFS_SEED;
        if (pos >= OFS_FLAGS)    return OFS_FLAGS;
        if (pos >= OFS_OVERLAY)  return OFS_OVERLAY;
        if (pos >= OFS_TERRAIN)  return OFS_TERRAIN;
        if (pos >= OFS_HEIGHT)   return OFS_HEIGHT;
        if (pos >= OFS_WIDTH)    return OFS_WIDTH;
        if (pos >= OFS_HDR_SIZE) return OFS_HDR_SIZE;
        if (pos >= OFS_VERSION)  return OFS_VERSION;
        return OFS_MAGIC;
    endfunction

    task automatic clear_header();
        foreach (hdr_mem[i]) hdr_mem[i] = '0;
        stored   = 0;
        answered = 1'b0;
    endtask

    // Advance the header state by one byte; queue a verdict when one is due
    task automatic take_header_byte(input logic [7:0] b, input logic l);
        t_result     r;
        logic        decided;
        logic [31:0] w, h, terrain, overlay;
        decided = 1'b0;
        r       = '0;
        if (answered) begin
            // Swallow bytes after the verdict; the last mark rearms
            if (l) clear_header();
        end else begin
            if (stored < HEADER_BYTES) begin
                hdr_mem[stored] = b;
                stored++;
            end
            if (stored == 4) begin
                if (hdr_mem[0] != "M" || hdr_mem[1] != "A" ||
                    hdr_mem[2] != "P" || hdr_mem[3] != "0") begin
                    decided        = 1'b1;
                    r.status       = ST_BAD_MAGIC;
                    r.error_offset = OFS_MAGIC;
                end
            end else if (stored == 8) begin
                if (hdr_field(OFS_HDR_SIZE, 2) != {16'd0, hdr_size_reg}) begin
                    decided        = 1'b1;
                    r.status       = ST_BAD_HDR_SIZE;
                    r.error_offset = OFS_HDR_SIZE;
                end
            end else if (stored >= HEADER_BYTES) begin
                decided = 1'b1;
                w       = hdr_field(OFS_WIDTH, 2);
                h       = hdr_field(OFS_HEIGHT, 2);
                terrain = hdr_field(OFS_TERRAIN, 4);
                overlay = hdr_field(OFS_OVERLAY, 4);
                if (w == 0 || h == 0) begin
                    r.status       = ST_ZERO_DIM;
                    r.error_offset = OFS_WIDTH;
                end else if (w > max_dim_reg || h > max_dim_reg) begin
                    r.status       = ST_DIM_LARGE;
                    r.error_offset = OFS_WIDTH;
                end else if (terrain != w * h) begin
                    r.status       = ST_TILE_MISMATCH;
                    r.error_offset = OFS_TERRAIN;
                end else if (overlay > terrain) begin
                    r.status       = ST_OVERLAY_EXCESS;
                    r.error_offset = OFS_OVERLAY;
                end else begin
                    r.status       = ST_OK;
                    r.error_offset = OFS_MAGIC;
                end
            end
            // A check point wins over an early end on the same byte
            if (!decided && l) begin
                decided        = 1'b1;
                r.status       = ST_TRUNCATED;
                r.error_offset = field_start_of(stored);
            end
            if (decided) begin
                r.map_version    = hdr_field(OFS_VERSION, 2);
                r.header_length  = hdr_field(OFS_HDR_SIZE, 2);
                r.map_width      = hdr_field(OFS_WIDTH, 2);
                r.map_height     = hdr_field(OFS_HEIGHT, 2);
                r.terrain_count  = hdr_field(OFS_TERRAIN, 4);
                r.overlay_count  = hdr_field(OFS_OVERLAY, 4);
                r.flag_word      = hdr_field(OFS_FLAGS, 4);
                r.seed_word      = hdr_field(OFS_SEED, 4);
                verdict_q.push_back(r);
                if (l) clear_header();
                else   answered = 1'b1;
            end
        end
    endtask

    task automatic match_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            fails++;
        end
    endtask

    // Compare one accepted result with the oldest pending verdict
    task automatic check_report(input logic [RESULT_W-1:0] data);
        t_result got, want;
        if (verdict_q.size() == 0) begin
            $error("result with no pending verdict: %h", data);
            fails++;
        end else begin
            got  = t_result'(data);
            want = verdict_q.pop_front();
            checked++;
            match_field("status",         want.status,         got.status);
            match_field("error_offset",   want.error_offset,   got.error_offset);
            match_field("map_version",    want.map_version,    got.map_version);
            match_field("header_length",  want.header_length,  got.header_length);
            match_field("map_width",      want.map_width,      got.map_width);
            match_field("map_height",     want.map_height,     got.map_height);
            match_field("terrain_count",  want.terrain_count,  got.terrain_count);
            match_field("overlay_count",  want.overlay_count,  got.overlay_count);
            match_field("flag_word",      want.flag_word,      got.flag_word);
            match_field("seed_word",      want.seed_word,      got.seed_word);
        end
    endtask

    // Sample all channels at the edge; results cannot come from this edge's byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hdr_size_reg = HDR_SIZE_RST;
            max_dim_reg  = MAX_DIM_RST;
            clear_header();
            verdict_q.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_report(i_out_data);
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_HDR_SIZE: hdr_size_reg = i_cfg_data;
                    CFG_MAX_DIM:  max_dim_reg  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                take_header_byte(i_in_byte, i_in_last);
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

>>> bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// Regression bench for map_header_validator_top: streams short directed
// buffers and then random headers, mostly well formed with one planted flaw
// or an early end, under several register settings and idle patterns.
// ---------------------------------------------------------------------------

module tb
    import mhv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int PHASE_BYTES   = 145;
    localparam int NUM_PHASES    = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 400;
    // Watchdog limit, set with ample margin over what a correct run needs
    localparam int CYCLE_LIMIT   = 200000;

    typedef enum {
        FLAW_NONE, FLAW_MAGIC, FLAW_SIZE, FLAW_ZERO, FLAW_LARGE, FLAW_TILES, FLAW_OVERLAY
    } t_header_flaw;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [RESULT_W-1:0]   m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    int                    fail_count;
    int                    pending;
    int                    checked;

    int                    send_idle_pct   = 0;
    int                    recv_stall_pct  = 0;
    logic                  hold_req        = 1'b0;
    logic                  hold_done       = 1'b0;
    int                    hold_left       = 0;
    int                    cycles          = 0;

    logic [CFG_W-1:0]      cur_hdr_size    = HDR_SIZE_RST;
    logic [CFG_W-1:0]      cur_max_dim     = MAX_DIM_RST;
    logic [7:0]            buf_bytes [$];
    int                    bytes_sent      = 0;
    int                    phase_bytes     = 0;
    int                    buffers_sent    = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    map_header_validator_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // byte_value[7:0]
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),    // status, error_offset, ... seed_word from bit 0
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    map_header_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_byte    (s_tdata),
        .i_in_last    (s_tlast),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Result side: random stalls, plus one long hold-off when requested
    always @(posedge clk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready  <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("map_header_validator_top regression: fail");
            $finish;
        end
    end

    // Offer one item, with random idle cycles ahead of it; hold until taken
    task automatic put_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < buf_bytes.size(); i++)
            put_byte(buf_bytes[i], i == buf_bytes.size() - 1);
        bytes_sent   += buf_bytes.size();
        phase_bytes  += buf_bytes.size();
        buffers_sent++;
    endtask

    task automatic push_le(input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++)
            buf_bytes.push_back(v[8*k +: 8]);
    endtask

    // Width or height inside the allowed range, extremes often; any nonzero value if the limit is zero
    function automatic logic [31:0] pick_dim();
        if (cur_max_dim == 0) return $urandom_range(65535, 1);
        case ($urandom_range(3))
            0:       return 1;
            1:       return 32'(cur_max_dim);
            default: return $urandom_range(cur_max_dim, 1);
        endcase
    endfunction

    function automatic t_header_flaw pick_flaw();
        int r;
        r = $urandom_range(99);
        if (r < 40) return FLAW_NONE;
        if (r < 50) return FLAW_MAGIC;
        if (r < 60) return FLAW_SIZE;
        if (r < 70) return FLAW_ZERO;
        if (r < 80) return FLAW_LARGE;
        if (r < 90) return FLAW_TILES;
        return FLAW_OVERLAY;
    endfunction

    // Build a full header with only the planted flaw; a zero limit also fails its dimensions
    task automatic build_header(input t_header_flaw flaw);
        logic [31:0] magic, w, h, terrain, overlay;
        logic [15:0] size_field;
        magic      = {"0", "P", "A", "M"};
        size_field = cur_hdr_size;
        w          = pick_dim();
        h          = pick_dim();
        terrain    = w * h;
        case ($urandom_range(2))
            0:       overlay = 0;
            1:       overlay = terrain;
            default: overlay = $urandom_range(terrain, 0);
        endcase
        if (flaw == FLAW_LARGE && cur_max_dim == 16'hFFFF) flaw = FLAW_TILES;
        if (flaw == FLAW_OVERLAY && terrain == 32'hFFFF_FFFF) flaw = FLAW_TILES;
        case (flaw)
            FLAW_MAGIC: magic[8*$urandom_range(3) + $urandom_range(7)] ^= 1'b1;
            FLAW_SIZE:  size_field ^= 16'($urandom_range(16'hFFFF, 1));
            FLAW_ZERO: begin
                if ($urandom_range(1)) w = 0;
                else                   h = 0;
            end
            FLAW_LARGE: begin
                if ($urandom_range(1)) w = $urandom_range(65535, cur_max_dim + 1);
                else                   h = $urandom_range(65535, cur_max_dim + 1);
                terrain = w * h;
            end
            FLAW_TILES:   terrain = terrain + $urandom_range(1000, 1);
            FLAW_OVERLAY: overlay = $urandom_range(32'hFFFF_FFFF, terrain + 1);
            default: ;
        endcase
        buf_bytes.delete();
        push_le(magic, 4);
        push_le($urandom, 2);
        push_le(32'(size_field), 2);
        push_le(w, 2);
        push_le(h, 2);
        push_le(terrain, 4);
        push_le(overlay, 4);
        push_le($urandom, 4);
        push_le($urandom, 4);
    endtask

    // Let the buffer run exactly, trail extra bytes, or end early
    task automatic shape_tail();
        int r, cut;
        r = $urandom_range(99);
        if (r < 20) begin
            repeat ($urandom_range(6, 1)) buf_bytes.push_back(8'($urandom));
        end else if (r < 55) begin
            cut = $urandom_range(27, 1);
            while (buf_bytes.size() > cut) void'(buf_bytes.pop_back());
        end
    endtask

    // Short random buffer, sometimes behind a good magic
    task automatic build_noise();
        buf_bytes.delete();
        if ($urandom_range(1)) push_le({"0", "P", "A", "M"}, 4);
        repeat ($urandom_range(10, 1)) buf_bytes.push_back(8'($urandom));
    endtask

    // Stop offering, wait for every verdict, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_limits(input logic [CFG_W-1:0] hsz, input logic [CFG_W-1:0] mdim);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HDR_SIZE;
        cfg_data  <= hsz;
        @(posedge clk);
        cfg_index <= CFG_MAX_DIM;
        cfg_data  <= mdim;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_hdr_size = hsz;
        cur_max_dim  = mdim;
    endtask

    initial begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_HDR_SIZE;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Pick registers and idle pattern for this phase
            case (ph)
                1: begin load_limits(16'd0, 16'hFFFF);  send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin
                    load_limits(16'hFFFF, 16'd1);
                    send_idle_pct  = 0;
                    recv_stall_pct = 64;
                    hold_req      <= 1'b1;
                end
                3: begin load_limits(HDR_SIZE_RST, 16'd0); send_idle_pct = 34; recv_stall_pct = 34; end
                4: begin
                    load_limits(16'($urandom), 16'($urandom_range(64, 1)));
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                5: begin
                    load_limits(16'($urandom), 16'($urandom_range(65535, 1)));
                    send_idle_pct  = 34;
                    recv_stall_pct = 34;
                end
                default: ;
            endcase
            phase_bytes = 0;

            if (ph == 0) begin
                // One byte that ends the buffer at once
                buf_bytes = '{8'hFF};
                send_buffer();
                // Bad magic decided on the last byte
                buf_bytes = '{"M", "A", "Q", "0"};
                send_buffer();
                // Good magic, then the buffer ends
                buf_bytes = '{"M", "A", "P", "0"};
                send_buffer();
                // Wrong header size decided on the last byte
                buf_bytes = '{"M", "A", "P", "0", 8'h00, 8'h00, 8'hFF, 8'hFF};
                send_buffer();
                // Right header size, then the buffer ends at the width field
                buf_bytes = '{"M", "A", "P", "0", 8'hFF, 8'hFF, HDR_SIZE_RST[7:0], 8'h00};
                send_buffer();
            end

            while (phase_bytes < PHASE_BYTES) begin
                if ($urandom_range(99) < 15) begin
                    build_noise();
                end else begin
                    build_header(pick_flaw());
                    shape_tail();
                end
                send_buffer();
            end
            drain();
        end

        $display("Covered %0d buffers (%0d bytes) over %0d register settings",
                 buffers_sent, bytes_sent, NUM_PHASES);
        $display("and four idle patterns; %0d results compared, with a long hold-off.",
                 checked);
        if (fail_count == 0) begin
            $display("map_header_validator_top regression: pass");
        end else begin
            $display("map_header_validator_top regression: fail");
        end
        $finish;
    end

endmodule
